/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list engine package
// Word layouts, action codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int IDX_W    = 6;
  localparam int PW       = POS_W + 1;

  localparam logic [ACTION_W-1:0] ACT_FRONT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SHOW   = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } ple_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [IDX_W-1:0]          item_index;
    logic                      last_item;
    logic                      list_empty;
    logic                      request_dropped;
  } ple_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_FRONT,
    S_DN,
    S_DUMP,
    S_DUMP_LD
  } ple_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DROP,
    OP_KEEP,
    OP_APPEND,
    OP_FRONT0,
    OP_UP_START,
    OP_DN_START,
    OP_DEC_NOW,
    OP_UP_STEP,
    OP_UP_LAST,
    OP_DN_STEP,
    OP_DN_LAST,
    OP_FRONT_HOLD,
    OP_DUMP_FIRST,
    OP_EMIT,
    OP_EMIT_EMPTY
  } ple_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_hit;
    logic pos_move;
    logic more_up;
    logic more_dn;
    logic last;
    logic out_free;
  } ple_status_t;

endpackage

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with insert, append, delete and dump.
// ----------------------------------------------------------------------------
// Requests enter on req (req_valid/req_stall) and carry an action, a value
// and a position. Each request edits the list and then the whole list goes
// out on rsp (rsp_valid/rsp_stall), one word per entry, front first, the
// final word marked last_item. An empty list gives one word with list_empty.
// An insert or append into a full list leaves the list alone and marks every
// word of its dump request_dropped.
// req_stall is high from acceptance until the last word of the dump is in
// the output register. An insert at the front of a list that was not empty
// first moves every entry up one place, and a delete of an entry before the
// end first moves each later entry down one place; then the dump reads the
// list out. The single memory port pair sets one move or one word per cycle.
// The next request can be taken while the last word still waits on rsp.
// When rsp_stall is high the output word holds and the dump pauses. Reset
// empties the list and drops any word in flight.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ple_pkg::ple_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ple_pkg::ple_rsp_t rsp
);
  import ple_pkg::*;

  ple_op_t     op;
  ple_status_t status;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (req.action),
    .status    (status),
    .op        (op)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* rtl/ple_datapath.sv */
// ----------------------------------------------------------------------------
// Positional list datapath
// Entry memory, count and index registers, move pipeline and output register.
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::ple_op_t   op,
  output ple_pkg::ple_status_t status,
  input  ple_pkg::ple_req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ple_pkg::ple_rsp_t  rsp
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] val_hold;
  logic signed [VALUE_W-1:0] wdata;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             idx_next;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic                      re;
  logic                      dropped;
  logic                      last;
  logic [PW-1:0]             pos_ext;
  logic [PW-1:0]             pos_p1;
  logic [PW-1:0]             count_ext;

  assign pos_ext   = {1'b0, req.position};
  assign pos_p1    = pos_ext + PW'(1);
  assign count_ext = PW'(count);
  assign last      = (CW'(idx) + CW'(1)) == count;

  assign status.full     = count == CW'(CAPACITY);
  assign status.empty    = count == '0;
  assign status.pos_hit  = pos_ext < count_ext;
  assign status.pos_move = pos_p1 < count_ext;
  assign status.more_up  = idx > AW'(1);
  assign status.more_dn  = (CW'(idx) + CW'(2)) < count;
  assign status.last     = last;
  assign status.out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    we         = 1'b0;
    waddr      = '0;
    wdata      = rdata;
    re         = 1'b0;
    raddr      = '0;
    count_next = count;
    idx_next   = idx;
    unique case (op)
      OP_APPEND: begin
        we         = 1'b1;
        waddr      = AW'(count);
        wdata      = req.value;
        count_next = count + CW'(1);
      end
      OP_FRONT0: begin
        we         = 1'b1;
        wdata      = req.value;
        count_next = count + CW'(1);
      end
      OP_UP_START: begin
        re       = 1'b1;
        raddr    = AW'(count - CW'(1));
        idx_next = AW'(count);
      end
      OP_DN_START: begin
        re       = 1'b1;
        raddr    = AW'(pos_p1);
        idx_next = AW'(req.position);
      end
      OP_DEC_NOW: begin
        count_next = count - CW'(1);
      end
      OP_UP_STEP: begin
        we       = 1'b1;
        waddr    = idx;
        re       = 1'b1;
        raddr    = idx - AW'(2);
        idx_next = idx - AW'(1);
      end
      OP_UP_LAST: begin
        we    = 1'b1;
        waddr = idx;
      end
      OP_DN_STEP: begin
        we       = 1'b1;
        waddr    = idx;
        re       = 1'b1;
        raddr    = idx + AW'(2);
        idx_next = idx + AW'(1);
      end
      OP_DN_LAST: begin
        we         = 1'b1;
        waddr      = idx;
        count_next = count - CW'(1);
      end
      OP_FRONT_HOLD: begin
        we         = 1'b1;
        wdata      = val_hold;
        count_next = count + CW'(1);
      end
      OP_DUMP_FIRST: begin
        re       = 1'b1;
        idx_next = '0;
      end
      OP_EMIT: begin
        re       = !last;
        raddr    = idx + AW'(1);
        idx_next = idx + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (op == OP_UP_START) begin
      val_hold <= req.value;
    end
    if (op == OP_DROP) begin
      dropped <= 1'b1;
    end else if (op == OP_KEEP || op == OP_APPEND || op == OP_FRONT0 ||
                 op == OP_UP_START || op == OP_DN_START || op == OP_DEC_NOW) begin
      dropped <= 1'b0;
    end
  end

  // output register: load a word when free, hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (op == OP_EMIT || op == OP_EMIT_EMPTY) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      rsp.item_value      <= rdata;
      rsp.item_index      <= IDX_W'(idx);
      rsp.last_item       <= last;
      rsp.list_empty      <= 1'b0;
      rsp.request_dropped <= dropped;
    end else if (op == OP_EMIT_EMPTY) begin
      rsp.item_value      <= '0;
      rsp.item_index      <= '0;
      rsp.last_item       <= 1'b1;
      rsp.list_empty      <= 1'b1;
      rsp.request_dropped <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1) ||
              count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.list_empty) |-> (rsp.last_item && rsp.item_index == '0))
    else $error("empty word not marked last");

endmodule

/* rtl/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// Positional list controller
// Sequences accept, entry moves and the list dump through datapath commands.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [ple_pkg::ACTION_W-1:0] action,
  input  ple_pkg::ple_status_t        status,
  output ple_pkg::ple_op_t            op
);
  import ple_pkg::*;

  ple_state_t state;
  ple_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DUMP;
          if (action == ACT_FRONT && !status.full && !status.empty) begin
            state_next = S_UP;
          end else if (action == ACT_DELETE && status.pos_move) begin
            state_next = S_DN;
          end
        end
      end
      S_UP: begin
        if (!status.more_up) begin
          state_next = S_FRONT;
        end
      end
      S_FRONT: state_next = S_DUMP;
      S_DN: begin
        if (!status.more_dn) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (!status.empty) begin
          state_next = S_DUMP_LD;
        end else if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP_LD: begin
        if (status.out_free && status.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op        = OP_NONE;
    req_stall = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (action)
            ACT_FRONT, ACT_APPEND: begin
              if (status.full) begin
                op = OP_DROP;
              end else if (action == ACT_APPEND) begin
                op = OP_APPEND;
              end else if (status.empty) begin
                op = OP_FRONT0;
              end else begin
                op = OP_UP_START;
              end
            end
            ACT_DELETE: begin
              if (status.pos_move) begin
                op = OP_DN_START;
              end else if (status.pos_hit) begin
                op = OP_DEC_NOW;
              end else begin
                op = OP_KEEP;
              end
            end
            ACT_SHOW: op = OP_KEEP;
            default:  op = OP_KEEP;
          endcase
        end
      end
      S_UP:    op = status.more_up ? OP_UP_STEP : OP_UP_LAST;
      S_FRONT: op = OP_FRONT_HOLD;
      S_DN:    op = status.more_dn ? OP_DN_STEP : OP_DN_LAST;
      S_DUMP: begin
        if (!status.empty) begin
          op = OP_DUMP_FIRST;
        end else if (status.out_free) begin
          op = OP_EMIT_EMPTY;
        end
      end
      S_DUMP_LD: begin
        if (status.out_free) begin
          op = OP_EMIT;
        end
      end
      default: op = OP_NONE;
    endcase
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !req_valid) |-> op == OP_NONE)
    else $error("command issued with no request");

  a_start_in_idle: assert property (@(posedge clk) disable iff (rst)
    (op == OP_APPEND || op == OP_FRONT0 || op == OP_UP_START || op == OP_DN_START ||
     op == OP_DROP || op == OP_KEEP || op == OP_DEC_NOW) |=> state != S_IDLE)
    else $error("request taken without a dump");

endmodule
